/* rtl/core/fpsa_pkg.sv */
package fpsa_pkg;

	localparam int ADDR_W  = 32;
	localparam int COUNT_W = 17;

	localparam logic [ADDR_W-1:0] LOWEST_RESET = 32'h8000_0000;
	localparam logic [ADDR_W-1:0] LIMIT_RESET  = 32'h8E00_0000;

	typedef enum logic [1:0] {
		CMD_ALLOC = 2'd0,
		CMD_FREE  = 2'd1,
		CMD_RANGE = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_EMPTY   = 2'd1,
		ST_BADADDR = 2'd2,
		ST_FULL    = 2'd3
	} status_t;

	typedef enum logic {
		REG_LOWEST = 1'b0,
		REG_LIMIT  = 1'b1
	} cfg_reg_t;

endpackage

/* rtl/core/fpsa_if.sv */
interface fpsa_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [31:0] address;
	logic [31:0] range_end;

	modport source (output valid, command, address, range_end, input ready);
	modport sink   (input valid, command, address, range_end, output ready);
endinterface

interface fpsa_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [31:0] page_address;
	logic [16:0] pages_free;

	modport source (output valid, status, page_address, pages_free, input ready);
	modport sink   (input valid, status, page_address, pages_free, output ready);
endinterface

/* rtl/core/fpsa_stack_ram.sv */
module fpsa_stack_ram #(
	parameter int DEPTH = 65536,
	parameter int WIDTH = 20
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/core/fpsa_page_check.sv */
module fpsa_page_check
	import fpsa_pkg::*;
#(
	parameter int PAGE_SHIFT = 12
) (
	input  logic [ADDR_W:0]   addr,
	input  logic [ADDR_W-1:0] lowest,
	input  logic [ADDR_W-1:0] limit,
	output logic              ok
);

	logic aligned;
	logic above_low;
	logic below_limit;

	assign aligned     = (addr[PAGE_SHIFT-1:0] == '0);
	assign above_low   = (addr >= {1'b0, lowest});
	assign below_limit = (addr < {1'b0, limit});
	assign ok          = aligned && above_low && below_limit;

endmodule

/* rtl/core/free_page_stack_allocator.sv */
// Channel   Dir  Handshake      Payload
// cmd_in    in   valid/ready    command, address, range_end
// rsp_out   out  valid/ready    status, page_address, pages_free
// cfg       in   cfg_we         cfg_idx, cfg_wdata (no read-back)
//
// A successful allocate or single free is accepted, then makes one stack memory access.
// Free range pushes its pages one push per cycle on the stack memory write port.
// One item is worked on at a time.
// The result register lets the next item be accepted while a result waits;
// a finished result held behind it keeps the block in S_HOLD until the output drains.
// Reset clears the stack pointer at once; no memory clearing pass is needed.
// PAGE_BYTES must be a power of two.
module free_page_stack_allocator
	import fpsa_pkg::*;
#(
	parameter int PAGE_BYTES = 4096,
	parameter int MAX_PAGES  = 65536
) (
	input  logic              clk,
	input  logic              arst_n,
	fpsa_cmd_if.sink          cmd_in,
	fpsa_rsp_if.source        rsp_out,
	input  logic              cfg_we,
	input  logic              cfg_idx,
	input  logic [ADDR_W-1:0] cfg_wdata
);

	localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
	localparam int PN_W       = ADDR_W - PAGE_SHIFT;
	localparam int IDX_W      = $clog2(MAX_PAGES);
	localparam int CNT_W      = $clog2(MAX_PAGES + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_POP,
		S_FREE,
		S_RANGE,
		S_HOLD
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  top_q;
	logic [CNT_W-1:0]  top_nxt;
	logic [ADDR_W-1:0] lowest_q;
	logic [ADDR_W-1:0] limit_q;
	logic [ADDR_W-1:0] addr_q;
	logic [ADDR_W-1:0] rend_q;
	logic [ADDR_W:0]   cursor_q;
	status_t           res_status_q;
	logic [ADDR_W-1:0] res_page_q;
	logic              rsp_valid_q;
	status_t           rsp_status_q;
	logic [ADDR_W-1:0] rsp_page_q;
	logic [CNT_W-1:0]  rsp_count_q;

	logic              accept;
	logic              out_free;
	logic              rsp_load;
	logic              full;
	logic [ADDR_W:0]   addr_up;
	logic [ADDR_W:0]   addr_round;
	logic [ADDR_W+1:0] cursor_step;
	logic              in_range;
	logic [ADDR_W:0]   chk_addr;
	logic              chk_ok;
	logic [CNT_W-1:0]  top_dec;

	logic              fin;
	status_t           fin_status;
	logic [ADDR_W-1:0] fin_page;

	logic              mem_we;
	logic              mem_re;
	logic [PN_W-1:0]   mem_wdata;
	logic [PN_W-1:0]   mem_rdata;
	logic [31:0]       count_ext;

	assign accept   = cmd_in.valid && cmd_in.ready;
	assign out_free = !rsp_valid_q || rsp_out.ready;
	assign rsp_load = out_free && (fin || state_q == S_HOLD);
	assign full     = (top_q >= CNT_W'(MAX_PAGES));
	assign top_dec  = top_q - CNT_W'(1);

	// round the range start up to a page, one bit wider so it never wraps
	assign addr_up     = {1'b0, cmd_in.address} + (ADDR_W+1)'(PAGE_BYTES - 1);
	assign addr_round  = {addr_up[ADDR_W:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
	assign cursor_step = {1'b0, cursor_q} + (ADDR_W+2)'(PAGE_BYTES);
	assign in_range    = (cursor_step <= {2'b00, rend_q});
	assign chk_addr    = (state_q == S_RANGE) ? cursor_q : {1'b0, addr_q};

	fpsa_page_check #(
		.PAGE_SHIFT(PAGE_SHIFT)
	) u_check (
		.addr   (chk_addr),
		.lowest (lowest_q),
		.limit  (limit_q),
		.ok     (chk_ok)
	);

	fpsa_stack_ram #(
		.DEPTH(MAX_PAGES),
		.WIDTH(PN_W)
	) u_stack (
		.clk   (clk),
		.we    (mem_we),
		.waddr (top_q[IDX_W-1:0]),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (top_dec[IDX_W-1:0]),
		.rdata (mem_rdata)
	);

	always_comb begin
		fin        = 1'b0;
		fin_status = ST_OK;
		fin_page   = '0;
		mem_we     = 1'b0;
		mem_re     = 1'b0;
		mem_wdata  = addr_q[ADDR_W-1:PAGE_SHIFT];
		top_nxt    = top_q;
		case (state_q)
			S_IDLE: begin
				if (accept && cmd_t'(cmd_in.command) == CMD_ALLOC && top_q != '0) begin
					mem_re  = 1'b1;
					top_nxt = top_dec;
				end
			end
			S_POP: begin
				fin      = 1'b1;
				fin_page = {mem_rdata, {PAGE_SHIFT{1'b0}}};
			end
			S_FREE: begin
				fin = 1'b1;
				if (!chk_ok) begin
					fin_status = ST_BADADDR;
				end else if (full) begin
					fin_status = ST_FULL;
				end else begin
					mem_we  = 1'b1;
					top_nxt = top_q + CNT_W'(1);
				end
			end
			S_RANGE: begin
				mem_wdata = cursor_q[ADDR_W-1:PAGE_SHIFT];
				if (!in_range) begin
					fin = 1'b1;
				end else if (!chk_ok) begin
					fin        = 1'b1;
					fin_status = ST_BADADDR;
				end else if (full) begin
					fin        = 1'b1;
					fin_status = ST_FULL;
				end else begin
					mem_we  = 1'b1;
					top_nxt = top_q + CNT_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lowest_q <= LOWEST_RESET;
			limit_q  <= LIMIT_RESET;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_idx))
				REG_LOWEST: lowest_q <= cfg_wdata;
				REG_LIMIT:  limit_q  <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			top_q        <= '0;
			addr_q       <= '0;
			rend_q       <= '0;
			cursor_q     <= '0;
			res_status_q <= ST_OK;
			res_page_q   <= '0;
			rsp_valid_q  <= 1'b0;
			rsp_status_q <= ST_OK;
			rsp_page_q   <= '0;
			rsp_count_q  <= '0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_out.ready) begin
				rsp_valid_q <= 1'b0;
			end
			top_q <= top_nxt;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						addr_q     <= cmd_in.address;
						rend_q     <= cmd_in.range_end;
						cursor_q   <= addr_round;
						res_page_q <= '0;
						case (cmd_t'(cmd_in.command))
							CMD_ALLOC: begin
								if (top_q != '0) begin
									state_q <= S_POP;
								end else begin
									res_status_q <= ST_EMPTY;
									state_q      <= S_HOLD;
								end
							end
							CMD_FREE:  state_q <= S_FREE;
							CMD_RANGE: state_q <= S_RANGE;
							default: begin
								res_status_q <= ST_OK;
								state_q      <= S_HOLD;
							end
						endcase
					end
				end
				S_HOLD: begin
					if (out_free) begin
						rsp_status_q <= res_status_q;
						rsp_page_q   <= res_page_q;
						rsp_count_q  <= top_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					if (mem_we) begin
						cursor_q <= cursor_step[ADDR_W:0];
					end
					if (fin) begin
						if (out_free) begin
							rsp_status_q <= fin_status;
							rsp_page_q   <= fin_page;
							rsp_count_q  <= top_nxt;
							state_q      <= S_IDLE;
						end else begin
							res_status_q <= fin_status;
							res_page_q   <= fin_page;
							state_q      <= S_HOLD;
						end
					end
				end
			endcase
		end
	end

	assign count_ext = 32'(rsp_count_q);

	assign cmd_in.ready         = (state_q == S_IDLE);
	assign rsp_out.valid        = rsp_valid_q;
	assign rsp_out.status       = rsp_status_q;
	assign rsp_out.page_address = rsp_page_q;
	assign rsp_out.pages_free   = count_ext[COUNT_W-1:0];

	a_top_bound: assert property (@(posedge clk) disable iff (!arst_n)
		top_q <= CNT_W'(MAX_PAGES))
		else $error("stack pointer beyond capacity");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re))
		else $error("stack memory read and write in one cycle");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_status_q == ST_EMPTY |-> rsp_count_q == '0)
		else $error("empty result with pages on the stack");

	a_err_no_page: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_status_q != ST_OK |-> rsp_page_q == '0)
		else $error("page address given on a failed command");

	a_pop_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cmd_t'(cmd_in.command) == CMD_ALLOC && top_q != '0
		|=> state_q == S_POP && top_q == $past(top_q) - CNT_W'(1))
		else $error("allocate did not pop");

endmodule

/* tb/page_stack_checker.sv */
`timescale 1ns / 1ps

module page_stack_checker
	import fpsa_pkg::*;
#(
	parameter int PAGE_BYTES = 4096,
	parameter int MAX_PAGES  = 65536
) (
	input  logic              clk,
	input  logic              arst_n,
	fpsa_cmd_if               cmd_mon,
	fpsa_rsp_if               rsp_mon,
	input  logic              cfg_we,
	input  logic              cfg_idx,
	input  logic [ADDR_W-1:0] cfg_wdata,
	output int                fail_count,
	output int                replies_open,
	output int                replies_seen,
	output int                empty_seen,
	output int                bad_seen,
	output int                full_seen
);

	localparam longint unsigned PB = PAGE_BYTES;
	localparam int REPORT_MAX = 40;

	typedef struct packed {
		status_t             status;
		logic [ADDR_W-1:0]   page_address;
		logic [COUNT_W-1:0]  pages_free;
	} reply_t;

	reply_t            replies_due[$];
	reply_t            want;
	bit                lone;
	logic [31:0]       page_numbers [MAX_PAGES];
	int unsigned       free_pages;
	logic [ADDR_W-1:0] lowest;
	logic [ADDR_W-1:0] limit;

	function automatic bit page_allowed(longint unsigned a);
		return (a % PB == 0) && (a >= lowest) && (a < limit);
	endfunction

	function automatic status_t push_page(longint unsigned a);
		if (!page_allowed(a))
			return ST_BADADDR;
		if (free_pages >= MAX_PAGES)
			return ST_FULL;
		page_numbers[free_pages] = 32'(a / PB);
		free_pages++;
		return ST_OK;
	endfunction

	function automatic reply_t apply_page_command(logic [1:0] command, logic [31:0] address,
			logic [31:0] range_end);
		reply_t r;
		longint unsigned p;
		r.status = ST_OK;
		r.page_address = '0;
		case (command)
			CMD_ALLOC: begin
				if (free_pages == 0) begin
					r.status = ST_EMPTY;
				end else begin
					free_pages--;
					r.page_address = ADDR_W'(64'(page_numbers[free_pages]) * PB);
				end
			end
			CMD_FREE: r.status = push_page(64'(address));
			CMD_RANGE: begin
				// start rounds up to a page; end test is done wide so it never wraps
				p = (64'(address) + PB - 1) / PB * PB;
				while (r.status == ST_OK && p + PB <= 64'(range_end)) begin
					r.status = push_page(p);
					if (r.status == ST_OK)
						p += PB;
				end
			end
			default: ;
		endcase
		r.pages_free = COUNT_W'(free_pages);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			replies_due.delete();
			free_pages = 0;
			lowest = LOWEST_RESET;
			limit = LIMIT_RESET;
			fail_count = 0;
			replies_seen = 0;
			empty_seen = 0;
			bad_seen = 0;
			full_seen = 0;
		end else begin
			// a reply taken at this edge belongs to an older item, so check it first
			if (rsp_mon.valid && rsp_mon.ready) begin
				replies_seen++;
				lone = (replies_due.size() == 0);
				if (!lone)
					want = replies_due.pop_front();
				if (lone || rsp_mon.status !== want.status
						|| rsp_mon.page_address !== want.page_address
						|| rsp_mon.pages_free !== want.pages_free) begin
					fail_count++;
					if (fail_count <= REPORT_MAX)
						$display("%0t: %s exp st %0d pg %h cnt %0d, got st %0d pg %h cnt %0d",
							$time, lone ? "reply with none outstanding," : "reply mismatch,",
							want.status, want.page_address, want.pages_free,
							rsp_mon.status, rsp_mon.page_address, rsp_mon.pages_free);
					else if (fail_count == REPORT_MAX + 1)
						$display("%0t: further mismatches not shown", $time);
				end
				case (rsp_mon.status)
					ST_EMPTY:   empty_seen++;
					ST_BADADDR: bad_seen++;
					ST_FULL:    full_seen++;
					default: ;
				endcase
			end
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_idx))
					REG_LOWEST: lowest = cfg_wdata;
					REG_LIMIT:  limit = cfg_wdata;
					default: ;
				endcase
			end
			if (cmd_mon.valid && cmd_mon.ready)
				replies_due.push_back(apply_page_command(cmd_mon.command, cmd_mon.address,
					cmd_mon.range_end));
		end
		replies_open = replies_due.size();
	end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
	import fpsa_pkg::*;

	localparam int PAGE_BYTES = 4096;
	localparam int MAX_PAGES  = 65536;
	localparam longint unsigned PB = PAGE_BYTES;
	localparam logic [1:0] CMD_NOP = 2'd3;    // unused code, must act as a no-op
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE = 6;
	// a full-stack range push pushes MAX_PAGES pages with nothing moving on the channels
	localparam int WATCHDOG = 4 * MAX_PAGES + 20000;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic              cfg_idx;
	logic [ADDR_W-1:0] cfg_wdata;

	fpsa_cmd_if cmd_if();
	fpsa_rsp_if rsp_if();

	int fail_count, replies_open, replies_seen, empty_seen, bad_seen, full_seen;
	int items_sent, idle_cycles, settings_used, no_gap_left;
	bit hold_req, burst;
	logic [ADDR_W-1:0] lo_addr, hi_addr;

	free_page_stack_allocator #(
		.PAGE_BYTES(PAGE_BYTES),
		.MAX_PAGES (MAX_PAGES)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_in   (cmd_if),
		.rsp_out  (rsp_if),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	page_stack_checker #(
		.PAGE_BYTES(PAGE_BYTES),
		.MAX_PAGES (MAX_PAGES)
	) u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_mon     (cmd_if),
		.rsp_mon     (rsp_if),
		.cfg_we      (cfg_we),
		.cfg_idx     (cfg_idx),
		.cfg_wdata   (cfg_wdata),
		.fail_count  (fail_count),
		.replies_open(replies_open),
		.replies_seen(replies_seen),
		.empty_seen  (empty_seen),
		.bad_seen    (bad_seen),
		.full_seen   (full_seen)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	always @(posedge clk) begin
		if (!arst_n || (cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG) begin
			$display("watchdog: nothing moved for %0d cycles", idle_cycles);
			$display("tb_top: FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 3);
		if (r < 94)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	// page-aligned address inside the current window, biased to its edges; any address if it holds no page
	function automatic logic [31:0] valid_page();
		longint unsigned first, count;
		int r;
		first = ({32'd0, lo_addr} + PB - 1) / PB * PB;
		if (first >= {32'd0, hi_addr})
			return $urandom();
		count = ({32'd0, hi_addr} - first + PB - 1) / PB;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 32'(first);
		if (r == 1)
			return 32'(first + (count - 1) * PB);
		return 32'(first + ({32'd0, $urandom()} % count) * PB);
	endfunction

	function automatic logic [31:0] bad_page();
		longint unsigned above;
		case ($urandom_range(0, 3))
			0: return valid_page() + $urandom_range(1, PAGE_BYTES - 1);
			1: begin
				if (lo_addr != 0)
					return 32'(({32'd0, lo_addr} - 1) / PB * PB);
				return $urandom();
			end
			2: begin
				above = ({32'd0, hi_addr} + PB - 1) / PB * PB;
				return 32'(above + $urandom_range(0, 2) * PB);
			end
			default: return $urandom();
		endcase
	endfunction

	task automatic pick_range(output logic [31:0] a, output logic [31:0] e);
		longint unsigned start, n;
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			n = $urandom_range(0, 4);
		else if (r < 96)
			n = $urandom_range(5, 40);
		else
			n = $urandom_range(100, 600);
		start = {32'd0, valid_page()};
		case ($urandom_range(0, 3))
			0: start = start - $urandom_range(1, PAGE_BYTES - 1);
			1: start = ({32'd0, hi_addr} / PB - $urandom_range(0, 3)) * PB;
			default: ;
		endcase
		a = 32'(start);
		e = 32'(start + n * PB);
		if ($urandom_range(0, 3) == 0)
			e = e + $urandom_range(0, PAGE_BYTES - 1);
	endtask

	task automatic send_item(input logic [1:0] c, input logic [31:0] a, input logic [31:0] e);
		int gap;
		gap = 0;
		if (no_gap_left > 0) begin
			no_gap_left--;
		end else if (!burst) begin
			if ($urandom_range(0, 99) < 8)
				no_gap_left = $urandom_range(10, 40);
			else if ($urandom_range(0, 99) < 45)
				gap = idle_gap();
		end
		if (gap > 0) begin
			cmd_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_if.valid <= 1'b1;
		cmd_if.command <= c;
		cmd_if.address <= a;
		cmd_if.range_end <= e;
		do @(posedge clk); while (!cmd_if.ready);
		items_sent++;
	endtask

	task automatic random_item(input int alloc_pct);
		logic [31:0] a, e;
		logic [1:0] c;
		int r;
		r = $urandom_range(0, 99);
		if (r < alloc_pct) begin
			send_item(CMD_ALLOC, $urandom(), $urandom());
		end else begin
			r = $urandom_range(0, 99);
			if (r < 50) begin
				send_item(CMD_FREE, valid_page(), $urandom());
			end else if (r < 65) begin
				send_item(CMD_FREE, bad_page(), $urandom());
			end else if (r < 90) begin
				pick_range(a, e);
				send_item(CMD_RANGE, a, e);
			end else begin
				c = $urandom_range(0, 3);
				a = $urandom();
				e = $urandom();
				// keep noisy ranges short
				if (c == CMD_RANGE)
					e = a + $urandom_range(0, 8 * PAGE_BYTES);
				send_item(c, a, e);
			end
		end
	endtask

	task automatic wait_idle();
		cmd_if.valid <= 1'b0;
		do @(posedge clk); while (replies_open != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_limits(input logic [31:0] lo, input logic [31:0] hi);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_idx <= REG_LOWEST;
		cfg_wdata <= lo;
		@(posedge clk);
		cfg_idx <= REG_LIMIT;
		cfg_wdata <= hi;
		@(posedge clk);
		cfg_we <= 1'b0;
		lo_addr = lo;
		hi_addr = hi;
		settings_used++;
	endtask

	initial begin : reply_sink
		int stall, run;
		stall = 0;
		run = 0;
		rsp_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				stall = HOLD_CYCLES;
			end
			if (stall > 0) begin
				rsp_if.ready <= 1'b0;
				stall--;
			end else if (run > 0) begin
				rsp_if.ready <= 1'b1;
				run--;
			end else if ($urandom_range(0, 99) < 10) begin
				run = $urandom_range(20, 80);
				rsp_if.ready <= 1'b1;
			end else if ($urandom_range(0, 99) < 60) begin
				rsp_if.ready <= 1'b1;
			end else begin
				stall = idle_gap() - 1;
				rsp_if.ready <= 1'b0;
			end
		end
	end

	initial begin : stimulus
		logic [31:0] lo, hi;
		int i, k;
		arst_n <= 1'b0;
		cmd_if.valid <= 1'b0;
		cmd_if.command <= CMD_ALLOC;
		cmd_if.address <= '0;
		cmd_if.range_end <= '0;
		cfg_we <= 1'b0;
		cfg_idx <= REG_LOWEST;
		cfg_wdata <= '0;
		lo_addr = LOWEST_RESET;
		hi_addr = LIMIT_RESET;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset window
		send_item(CMD_ALLOC, 32'h0, 32'h0);
		send_item(CMD_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(CMD_FREE, 32'h8000_0000, 32'h0);
		send_item(CMD_FREE, 32'h8DFF_F000, 32'h0);
		send_item(CMD_FREE, 32'h8E00_0000, 32'h0);
		send_item(CMD_FREE, 32'h7FFF_F000, 32'h0);
		send_item(CMD_FREE, 32'h8000_0001, 32'h0);
		send_item(CMD_FREE, 32'hFFFF_FFFF, 32'h0);
		send_item(CMD_FREE, 32'h0, 32'h0);
		send_item(CMD_ALLOC, 32'h0, 32'h0);
		send_item(CMD_RANGE, 32'h8000_1001, 32'h8000_4000);
		send_item(CMD_RANGE, 32'h8001_0000, 32'h8001_0FFF);
		send_item(CMD_RANGE, 32'h8DFF_D000, 32'h8E00_2000);
		send_item(CMD_RANGE, 32'h7FFF_E000, 32'h8000_2000);
		send_item(CMD_RANGE, 32'hFFFF_F001, 32'hFFFF_FFFF);
		send_item(CMD_RANGE, 32'h8000_5000, 32'h8000_1000);
		repeat (3) send_item(CMD_ALLOC, $urandom(), $urandom());
		send_item(CMD_NOP, $urandom(), $urandom());

		for (i = 0; i < 150; i++) begin
			// long reply stall while items keep coming back to back
			if (i == 60) begin
				hold_req = 1'b1;
				burst = 1'b1;
			end
			if (i == 76)
				burst = 1'b0;
			random_item(45);
		end

		write_limits(32'h0, 32'hFFFF_FFFF);
		send_item(CMD_FREE, 32'h0, 32'h0);
		send_item(CMD_FREE, 32'hFFFF_F000, 32'h0);
		send_item(CMD_RANGE, 32'hFFFF_E000, 32'hFFFF_FFFF);
		send_item(CMD_RANGE, 32'h0, 32'h0000_3000);
		send_item(CMD_ALLOC, 32'h0, 32'h0);
		for (i = 0; i < 110; i++)
			random_item(50);

		write_limits(32'hFFFF_FFFF, 32'h0);
		for (i = 0; i < 30; i++)
			random_item(60);

		for (k = 0; k < 4; k++) begin
			lo = $urandom();
			if (k % 2 == 0)
				lo[11:0] = '0;
			hi = lo + $urandom_range(PAGE_BYTES, 1 << 24);
			if (k == 3)
				hi = lo;
			write_limits(lo, hi);
			for (i = 0; i < 40; i++)
				random_item(75);
		end

		// fill the stack to the top, then work around the full mark
		write_limits(32'h0, 32'hFFFF_FFFF);
		send_item(CMD_RANGE, 32'h0, 32'h1010_0000);
		send_item(CMD_FREE, 32'h5000_0000, 32'h0);
		send_item(CMD_FREE, 32'h5000_0800, 32'h0);
		send_item(CMD_RANGE, 32'h6000_0000, 32'h6000_2000);
		repeat (3) send_item(CMD_ALLOC, 32'h0, 32'h0);
		send_item(CMD_FREE, 32'h5000_0000, 32'h0);
		send_item(CMD_RANGE, 32'h6000_0000, 32'h6000_2000);
		send_item(CMD_RANGE, 32'h6000_0000, 32'h6000_0FFF);
		for (i = 0; i < 20; i++)
			random_item(50);

		cmd_if.valid <= 1'b0;
		do @(posedge clk); while (replies_open != 0);
		repeat (2 * SETTLE) @(posedge clk);

		$display("summary: %0d items over %0d address windows, %0d replies checked",
			items_sent, settings_used + 1, replies_seen);
		$display("summary: replies with no free page %0d, bad address %0d, stack full %0d",
			empty_seen, bad_seen, full_seen);
		if (fail_count == 0 && replies_open == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule

/* sim.f */
rtl/core/fpsa_pkg.sv
rtl/core/fpsa_if.sv
rtl/core/fpsa_stack_ram.sv
rtl/core/fpsa_page_check.sv
rtl/core/free_page_stack_allocator.sv
tb/page_stack_checker.sv
tb/tb_top.sv
